// ===== src/arbd_pkg.sv =====
`default_nettype none

package arbd_pkg;

    localparam int CHANNELS = 64;
    localparam int ADC_BITS = 10;

    // configuration register indexes
    localparam logic REG_CHAIN_COUNT     = 1'b0;
    localparam logic REG_ASICS_PER_CHAIN = 1'b1;

    // result kinds (tuser)
    localparam logic KIND_ADC     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // result payload, first member in the highest bits so asic_number lands at bit 0
    typedef struct packed {
        logic [63:0] hit_map;
        logic [6:0]  header_flags;
        logic [6:0]  hit_count;
        logic [9:0]  common_mode;
        logic [9:0]  reference;
        logic [9:0]  adc_value;
        logic [5:0]  channel;
        logic [5:0]  asic_number;
    } rdata_t;

    // zero counts as one, anything above eight counts as eight
    function automatic logic [3:0] limit_of(input logic [3:0] v);
        logic [3:0] r;
        if (v == 4'd0) begin
            r = 4'd1;
        end else if (v > 4'd8) begin
            r = 4'd8;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/asic_readout_bitstream_decoder.sv =====
`default_nettype none
// sequencing: a word is parsed one bit per cycle while no held result is stalled, then
// the flush state releases the last result of the word and the block returns to idle;
// only in idle is the next word accepted, so words do not overlap. A held result that
// cannot move on freezes the bit-serial parser until the output register frees
// reset: aresetn is synchronous and active low; it clears the parser, the handshake state
// and sets both configuration registers to one

module asic_readout_bitstream_decoder (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // payload_word
    input  wire logic [0:0]   s_tuser,   // start_of_event
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [119:0]      m_tdata,   // asic_number, channel, adc_value, reference,
                                         // common_mode, hit_count, header_flags, hit_map
    output logic [0:0]        m_tuser,   // record_kind
    output logic              m_tlast,   // last_of_word
    // configuration writes
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [3:0]   cfg_wdata
);

    // word sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BITS  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // record parser phases
    localparam logic [3:0] PH_HEAD  = 4'd0;
    localparam logic [3:0] PH_MAP   = 4'd1;
    localparam logic [3:0] PH_FLAG  = 4'd2;
    localparam logic [3:0] PH_REF   = 4'd3;
    localparam logic [3:0] PH_ADC   = 4'd4;
    localparam logic [3:0] PH_CMN   = 4'd5;
    localparam logic [3:0] PH_TRAIL = 4'd6;
    localparam logic [3:0] PH_SKIP  = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;

    localparam logic [6:0] LAST_MAP_BIT = 7'(arbd_pkg::CHANNELS - 1);
    localparam logic [6:0] LAST_VAL_BIT = 7'(arbd_pkg::ADC_BITS - 1);

    // configuration
    logic [3:0] chain_count_reg;
    logic [3:0] apc_reg;

    // word sequencer
    logic [1:0]  state_reg;
    logic [31:0] word_reg;
    logic [4:0]  bitpos_reg;

    // parser state
    logic [3:0]  phase_reg,  phase_next;
    logic [6:0]  fcnt_reg,   fcnt_next;
    logic [6:0]  hdr_reg,    hdr_next;
    logic [63:0] map_reg,    map_next;
    logic [6:0]  hits_reg,   hits_next;
    logic [6:0]  remain_reg, remain_next;
    logic [9:0]  ref_reg,    ref_next;
    logic [9:0]  val_reg,    val_next;
    logic [3:0]  asic_reg,   asic_next;
    logic [3:0]  chain_reg,  chain_next;

    // hit channel scanner: the next hit channel is always brought to bit 63
    logic [63:0] scan_reg,   scan_next;
    logic [6:0]  scan_ch_reg, scan_ch_next;
    logic [3:0]  lead;

    // result staging: one held result, so the last one of a word can be marked
    arbd_pkg::rdata_t held_data_reg;
    logic             held_kind_reg;
    logic             held_valid_reg;

    logic             accept;
    logic             out_free;
    logic             stall;
    logic             take;
    logic             in_bit;
    logic             emit;
    logic             emit_kind;
    arbd_pkg::rdata_t emit_data;
    logic             finish;
    logic             scan_load;
    logic             consume;
    logic             move_out;
    logic [3:0]       apc_lim;
    logic [3:0]       cc_lim;
    logic [7:0]       asic_prod;
    logic [5:0]       asic_num;
    logic [3:0]       asic_inc;
    logic [3:0]       chain_inc;
    logic [4:0]       next_pos;
    logic [6:0]       skip_len;
    logic [6:0]       skip_dec;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign stall    = held_valid_reg && !out_free;
    assign take     = (state_reg == ST_BITS) && !stall;
    assign in_bit   = word_reg[31];

    assign apc_lim   = arbd_pkg::limit_of(apc_reg);
    assign cc_lim    = arbd_pkg::limit_of(chain_count_reg);
    assign asic_prod = {4'd0, chain_reg} * {4'd0, apc_lim};
    assign asic_num  = asic_prod[5:0] + {2'b00, asic_reg};
    assign asic_inc  = asic_reg + 4'd1;
    assign chain_inc = chain_reg + 4'd1;
    // skip to the word boundary after the current bit, then one whole word more
    assign next_pos  = bitpos_reg + 5'd1;
    assign skip_len  = (next_pos == 5'd0) ? 7'd32 : 7'd64 - {2'b00, next_pos};
    assign skip_dec  = (fcnt_reg != 7'd0) ? fcnt_reg - 7'd1 : 7'd0;

    // leading zeros in the top digit of the scanner
    always_comb begin
        lead = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (scan_reg[56 + i]) begin
                lead = 4'(7 - i);
            end
        end
    end

    // one bit of the record parser
    always_comb begin
        phase_next  = phase_reg;
        fcnt_next   = fcnt_reg;
        hdr_next    = hdr_reg;
        map_next    = map_reg;
        hits_next   = hits_reg;
        remain_next = remain_reg;
        ref_next    = ref_reg;
        val_next    = val_reg;
        asic_next   = asic_reg;
        chain_next  = chain_reg;
        emit        = 1'b0;
        emit_kind   = arbd_pkg::KIND_SUMMARY;
        emit_data   = '0;
        finish      = 1'b0;
        scan_load   = 1'b0;
        consume     = 1'b0;
        emit_data.asic_number = asic_num;

        if (accept && s_tuser[0]) begin
            phase_next  = PH_HEAD;
            fcnt_next   = '0;
            hdr_next    = '0;
            map_next    = '0;
            hits_next   = '0;
            remain_next = '0;
            ref_next    = '0;
            val_next    = '0;
            asic_next   = '0;
            chain_next  = '0;
        end else if (take) begin
            unique case (phase_reg)
                PH_HEAD: begin
                    hdr_next  = {hdr_reg[5:0], in_bit};
                    fcnt_next = fcnt_reg + 7'd1;
                    if (fcnt_reg >= 7'd4) begin
                        if (!hdr_next[3]) begin
                            // empty record
                            emit                   = 1'b1;
                            emit_data.header_flags = {hdr_next[4:0], 2'b00};
                            finish                 = 1'b1;
                        end else begin
                            hdr_next  = {hdr_next[4:0], 2'b00};
                            map_next  = '0;
                            hits_next = '0;
                            fcnt_next = '0;
                            phase_next = PH_MAP;
                        end
                    end
                end
                PH_MAP: begin
                    map_next  = {map_reg[62:0], in_bit};
                    hits_next = hits_reg + {6'd0, in_bit};
                    fcnt_next = fcnt_reg + 7'd1;
                    if (fcnt_reg >= LAST_MAP_BIT) begin
                        scan_load   = 1'b1;
                        remain_next = hits_next;
                        fcnt_next   = '0;
                        phase_next  = PH_FLAG;
                    end
                end
                PH_FLAG: begin
                    hdr_next   = hdr_reg | {5'd0, in_bit, 1'b0};
                    ref_next   = '0;
                    fcnt_next  = '0;
                    phase_next = PH_REF;
                end
                PH_REF: begin
                    ref_next  = ref_reg | (10'(in_bit) << fcnt_reg[3:0]);
                    fcnt_next = fcnt_reg + 7'd1;
                    if (fcnt_reg >= LAST_VAL_BIT) begin
                        fcnt_next  = '0;
                        val_next   = '0;
                        phase_next = (remain_reg != 7'd0) ? PH_ADC : PH_CMN;
                    end
                end
                PH_ADC: begin
                    val_next  = val_reg | (10'(in_bit) << fcnt_reg[3:0]);
                    fcnt_next = fcnt_reg + 7'd1;
                    if (fcnt_reg >= LAST_VAL_BIT) begin
                        emit                   = 1'b1;
                        emit_kind              = arbd_pkg::KIND_ADC;
                        emit_data.channel      = scan_ch_reg[5:0];
                        emit_data.adc_value    = val_next;
                        emit_data.reference    = ref_reg;
                        emit_data.hit_count    = hits_reg;
                        emit_data.header_flags = hdr_reg;
                        emit_data.hit_map      = map_reg;
                        consume     = 1'b1;
                        fcnt_next   = '0;
                        val_next    = '0;
                        remain_next = remain_reg - 7'd1;
                        if (remain_reg == 7'd1) begin
                            phase_next = PH_CMN;
                        end
                    end
                end
                PH_CMN: begin
                    val_next  = val_reg | (10'(in_bit) << fcnt_reg[3:0]);
                    fcnt_next = fcnt_reg + 7'd1;
                    if (fcnt_reg >= LAST_VAL_BIT) begin
                        fcnt_next  = '0;
                        phase_next = PH_TRAIL;
                    end
                end
                PH_TRAIL: begin
                    hdr_next               = hdr_reg | {6'd0, in_bit};
                    emit                   = 1'b1;
                    emit_data.reference    = ref_reg;
                    emit_data.common_mode  = val_reg;
                    emit_data.hit_count    = hits_reg;
                    emit_data.header_flags = hdr_next;
                    emit_data.hit_map      = map_reg;
                    finish                 = 1'b1;
                end
                PH_SKIP: begin
                    fcnt_next = skip_dec;
                    if (skip_dec == 7'd0) begin
                        phase_next = PH_HEAD;
                        hdr_next   = '0;
                        map_next   = '0;
                        hits_next  = '0;
                        remain_next = '0;
                        ref_next   = '0;
                        val_next   = '0;
                    end
                end
                default: begin
                    // event finished, bits ignored until the next start of event
                end
            endcase

            if (finish) begin
                if (asic_inc >= apc_lim) begin
                    asic_next  = '0;
                    chain_next = chain_inc;
                end else begin
                    asic_next  = asic_inc;
                end
                if ((asic_inc >= apc_lim) && (chain_inc >= cc_lim)) begin
                    phase_next = PH_DONE;
                end else begin
                    phase_next  = (asic_inc >= apc_lim) ? PH_SKIP : PH_HEAD;
                    fcnt_next   = (asic_inc >= apc_lim) ? skip_len : 7'd0;
                    hdr_next    = '0;
                    map_next    = '0;
                    hits_next   = '0;
                    remain_next = '0;
                    ref_next    = '0;
                    val_next    = '0;
                end
            end
        end
    end

    // scanner: load at the end of the map, drop the channel just used, else skip zeros
    always_comb begin
        scan_next    = scan_reg;
        scan_ch_next = scan_ch_reg;
        if (scan_load) begin
            scan_next    = map_next;
            scan_ch_next = '0;
        end else if (consume) begin
            scan_next    = {scan_reg[62:0], 1'b0};
            scan_ch_next = scan_ch_reg + 7'd1;
        end else if (!scan_reg[63]) begin
            scan_next    = scan_reg << lead;
            scan_ch_next = scan_ch_reg + {3'd0, lead};
        end
    end

    assign move_out = held_valid_reg
                      && ((take && emit) || ((state_reg == ST_FLUSH) && out_free));

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_count_reg <= 4'd1;
            apc_reg         <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                arbd_pkg::REG_CHAIN_COUNT:     chain_count_reg <= cfg_wdata;
                arbd_pkg::REG_ASICS_PER_CHAIN: apc_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // word sequencer and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            bitpos_reg <= '0;
            phase_reg  <= PH_HEAD;
            fcnt_reg   <= '0;
            hdr_reg    <= '0;
            map_reg    <= '0;
            hits_reg   <= '0;
            remain_reg <= '0;
            ref_reg    <= '0;
            val_reg    <= '0;
            asic_reg   <= '0;
            chain_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            fcnt_reg   <= fcnt_next;
            hdr_reg    <= hdr_next;
            map_reg    <= map_next;
            hits_reg   <= hits_next;
            remain_reg <= remain_next;
            ref_reg    <= ref_next;
            val_reg    <= val_next;
            asic_reg   <= asic_next;
            chain_reg  <= chain_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        bitpos_reg <= '0;
                        state_reg  <= ST_BITS;
                    end
                end
                ST_BITS: begin
                    if (take) begin
                        bitpos_reg <= bitpos_reg + 5'd1;
                        if (bitpos_reg == 5'd31) begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!held_valid_reg || out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload shift register and scanner
    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= s_tdata;
        end else if (take) begin
            word_reg <= {word_reg[30:0], 1'b0};
        end
        scan_reg    <= scan_next;
        scan_ch_reg <= scan_ch_next;
    end

    // held result and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            m_tvalid       <= 1'b0;
        end else begin
            if (take && emit) begin
                held_valid_reg <= 1'b1;
            end else if (move_out) begin
                held_valid_reg <= 1'b0;
            end
            if (move_out) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            held_data_reg <= emit_data;
            held_kind_reg <= emit_kind;
        end
        if (move_out) begin
            m_tdata    <= held_data_reg;
            m_tuser[0] <= held_kind_reg;
            m_tlast    <= (state_reg == ST_FLUSH);
        end
    end

    // the scanner has the next hit channel ready when an adc value completes
    a_scan_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && emit && (emit_kind == arbd_pkg::KIND_ADC)) |-> scan_reg[63])
        else $error("hit channel not found in time");

    // no result is left behind when a new word may be accepted
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !held_valid_reg)
        else $error("held result left over at word end");

    // adc values still to come never exceed the hits of the record
    a_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        remain_reg <= hits_reg)
        else $error("remaining hit count out of range");

    // asic index stays within one chain
    a_asic: assert property (@(posedge aclk) disable iff (!aresetn)
        asic_reg < 4'd8)
        else $error("asic index out of range");

    // a result is never overwritten while the output register is stalled
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !move_out)
        else $error("output register overrun");

endmodule

`default_nettype wire

// ===== tb/asic_readout_bitstream_decoder_tb.sv =====
`default_nettype none

module asic_readout_bitstream_decoder_tb;

    // generous cycle budget, well above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    // lets a word that yields nothing run through the block before the next step
    localparam int SETTLE_CYCLES = 40;

    // bit-serial parser phases of the predictor
    typedef enum logic [3:0] {
        P_HEADER,
        P_MAP,
        P_FLAG,
        P_REF,
        P_ADC,
        P_CMN,
        P_TRAILER,
        P_SKIP,
        P_DONE
    } parse_phase_t;

    // one payload word on its way into the block
    typedef struct packed {
        logic [31:0] word;
        logic        sof;
    } payload_item_t;

    // one predicted result transaction
    typedef struct packed {
        logic             kind;
        logic             last;
        arbd_pkg::rdata_t data;
    } readout_record_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;    // payload_word
    logic [0:0]   s_tuser = '0;    // start_of_event
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;         // asic_number, channel, adc_value, reference,
                                   // common_mode, hit_count, header_flags, hit_map
    logic [0:0]   m_tuser;         // record_kind
    logic         m_tlast;         // last_of_word
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [3:0]   cfg_wdata = '0;

    // stimulus and scoreboard storage
    payload_item_t   pending_words[$];
    readout_record_t expected_records[$];
    readout_record_t word_results[$];
    logic            stream_bits[$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   words_sent = 0;
    logic steady = 1'b0;    // when set neither side idles

    // predictor copy of the configuration registers
    logic [3:0] cfg_chains = 4'd1;
    logic [3:0] cfg_asics = 4'd1;

    // predictor copy of the parser state
    parse_phase_t dec_phase = P_HEADER;
    int           bit_cnt = 0;
    logic [6:0]   hdr_bits = '0;
    logic [63:0]  hit_map_acc = '0;
    logic [63:0]  hits_left = '0;
    logic [6:0]   hit_total = '0;
    logic [9:0]   ref_acc = '0;
    logic [9:0]   val_acc = '0;
    logic [5:0]   asic_idx = '0;
    logic [3:0]   chain_idx = '0;

    asic_readout_bitstream_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // a register value of zero behaves as one, anything above eight as eight
    function automatic int effective(input logic [3:0] v);
        if (v == 4'd0) begin
            return 1;
        end else if (v > 4'd8) begin
            return 8;
        end
        return int'(v);
    endfunction

    task automatic start_record();
        dec_phase = P_HEADER;
        bit_cnt = 0;
        hdr_bits = '0;
        hit_map_acc = '0;
        hits_left = '0;
        hit_total = '0;
        ref_acc = '0;
        val_acc = '0;
    endtask

    // the result carries the asic position as it stood before the record closes
    task automatic emit_result(input logic kind, input logic [5:0] chan,
                               input logic [9:0] adc, input logic [9:0] ref_val,
                               input logic [9:0] cm_val, input logic [6:0] hits,
                               input logic [6:0] flags, input logic [63:0] map);
        readout_record_t r;
        if (word_results.size() >= 8) begin
            return;
        end
        r.kind = kind;
        r.last = 1'b0;
        r.data.asic_number = 6'(int'(chain_idx) * effective(cfg_asics) + int'(asic_idx));
        r.data.channel = chan;
        r.data.adc_value = adc;
        r.data.reference = ref_val;
        r.data.common_mode = cm_val;
        r.data.hit_count = hits;
        r.data.header_flags = flags;
        r.data.hit_map = map;
        word_results.push_back(r);
    endtask

    // step to the next asic; at the end of a chain skip to the word boundary and one
    // word beyond, at the end of the last chain stop until the next event
    task automatic close_record(input int pos);
        int nxt_pos;
        asic_idx = asic_idx + 6'd1;
        if (int'(asic_idx) >= effective(cfg_asics)) begin
            asic_idx = '0;
            chain_idx = chain_idx + 4'd1;
            if (int'(chain_idx) >= effective(cfg_chains)) begin
                dec_phase = P_DONE;
                return;
            end
            nxt_pos = (pos + 1) & 31;
            start_record();
            bit_cnt = ((nxt_pos != 0) ? 32 - nxt_pos : 0) + 32;
            dec_phase = P_SKIP;
            return;
        end
        start_record();
    endtask

    task automatic take_bit(input logic b, input int pos);
        int   c;
        int   ch;
        logic found;
        case (dec_phase)
            P_HEADER: begin
                hdr_bits = {hdr_bits[5:0], b};
                bit_cnt++;
                if (bit_cnt >= 5) begin
                    // second header bit clear: empty record, summary only
                    if (hdr_bits[3] == 1'b0) begin
                        emit_result(arbd_pkg::KIND_SUMMARY, '0, '0, '0, '0, '0,
                                    hdr_bits << 2, '0);
                        close_record(pos);
                    end else begin
                        hdr_bits = hdr_bits << 2;
                        hit_map_acc = '0;
                        bit_cnt = 0;
                        dec_phase = P_MAP;
                    end
                end
            end
            P_MAP: begin
                hit_map_acc = {hit_map_acc[62:0], b};
                bit_cnt++;
                if (bit_cnt >= arbd_pkg::CHANNELS) begin
                    hits_left = hit_map_acc;
                    hit_total = 7'($countones(hit_map_acc));
                    bit_cnt = 0;
                    dec_phase = P_FLAG;
                end
            end
            P_FLAG: begin
                hdr_bits[1] = hdr_bits[1] | b;
                ref_acc = '0;
                bit_cnt = 0;
                dec_phase = P_REF;
            end
            P_REF: begin
                ref_acc = ref_acc | (10'(b) << bit_cnt);
                bit_cnt++;
                if (bit_cnt >= arbd_pkg::ADC_BITS) begin
                    bit_cnt = 0;
                    val_acc = '0;
                    dec_phase = (hits_left != '0) ? P_ADC : P_CMN;
                end
            end
            P_ADC: begin
                val_acc = val_acc | (10'(b) << bit_cnt);
                bit_cnt++;
                if (bit_cnt >= arbd_pkg::ADC_BITS) begin
                    // lowest pending channel takes this value
                    found = 1'b0;
                    ch = 0;
                    for (c = 0; c < arbd_pkg::CHANNELS; c++) begin
                        if (!found && hits_left[63 - c]) begin
                            ch = c;
                            found = 1'b1;
                        end
                    end
                    hits_left[63 - ch] = 1'b0;
                    emit_result(arbd_pkg::KIND_ADC, 6'(ch), val_acc, ref_acc, '0, hit_total,
                                hdr_bits, hit_map_acc);
                    bit_cnt = 0;
                    val_acc = '0;
                    if (hits_left == '0) begin
                        dec_phase = P_CMN;
                    end
                end
            end
            P_CMN: begin
                val_acc = val_acc | (10'(b) << bit_cnt);
                bit_cnt++;
                if (bit_cnt >= arbd_pkg::ADC_BITS) begin
                    bit_cnt = 0;
                    dec_phase = P_TRAILER;
                end
            end
            P_TRAILER: begin
                hdr_bits[0] = hdr_bits[0] | b;
                emit_result(arbd_pkg::KIND_SUMMARY, '0, '0, ref_acc, val_acc, hit_total,
                            hdr_bits, hit_map_acc);
                close_record(pos);
            end
            P_SKIP: begin
                if (bit_cnt > 0) begin
                    bit_cnt--;
                end
                if (bit_cnt == 0) begin
                    start_record();
                end
            end
            default: begin
            end
        endcase
    endtask

    // works out every result that one accepted payload word causes
    task automatic decode_word(input logic [31:0] w, input logic sof);
        int i;
        readout_record_t r;
        word_results.delete();
        if (sof) begin
            start_record();
            asic_idx = '0;
            chain_idx = '0;
        end
        for (i = 0; i < 32; i++) begin
            take_bit(w[31 - i], i);
        end
        for (i = 0; i < word_results.size(); i++) begin
            r = word_results[i];
            r.last = (i == word_results.size() - 1);
            expected_records.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: presents queued payload words, predicts on each transaction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : payload_driver
        payload_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_word(s_tdata, s_tuser[0]);
            end
            // a word still waiting for its handshake stays put
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
                    nxt = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.word;
                    s_tuser <= nxt.sof;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, field by field comparison
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        readout_record_t  want;
        arbd_pkg::rdata_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_records.size() == 0) begin
                    $error("result transaction with nothing expected: kind %0d data %0h",
                           m_tuser[0], m_tdata);
                    error_count++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("record_kind", want.kind, m_tuser[0]);
                    check_field("last_of_word", want.last, m_tlast);
                    check_field("asic_number", want.data.asic_number, got.asic_number);
                    check_field("channel", want.data.channel, got.channel);
                    check_field("adc_value", want.data.adc_value, got.adc_value);
                    check_field("reference", want.data.reference, got.reference);
                    check_field("common_mode", want.data.common_mode, got.common_mode);
                    check_field("hit_count", want.data.hit_count, got.hit_count);
                    check_field("header_flags", want.data.header_flags, got.header_flags);
                    check_field("hit_map", want.data.hit_map, got.hit_map);
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 26);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_word(input logic [31:0] w, input logic sof);
        payload_item_t item;
        item.word = w;
        item.sof = sof;
        pending_words.push_back(item);
        words_sent++;
    endtask

    task automatic push_field(input logic [63:0] v, input int n, input logic lsb_first);
        int i;
        for (i = 0; i < n; i++) begin
            stream_bits.push_back(lsb_first ? v[i] : v[n - 1 - i]);
        end
    endtask

    // one asic record; head5 holds the four header bits and the fifth bit, msb first
    task automatic add_record(input logic [4:0] head5, input logic [63:0] map,
                              input logic [9:0] ref_val, input logic [9:0] cm_val,
                              input int adc_fixed);
        int         k;
        logic [9:0] adc;
        push_field(head5, 5, 1'b0);
        if (head5[3]) begin
            push_field(map, 64, 1'b0);
            stream_bits.push_back(1'($urandom_range(0, 1)));
            push_field(ref_val, 10, 1'b1);
            for (k = 0; k < $countones(map); k++) begin
                adc = (adc_fixed < 0) ? 10'($urandom) : 10'(adc_fixed);
                push_field(adc, 10, 1'b1);
            end
            push_field(cm_val, 10, 1'b1);
            stream_bits.push_back(1'($urandom_range(0, 1)));
        end
    endtask

    // fill to the word boundary; between chains one further word is padding too
    task automatic pad_chain(input logic is_last_chain);
        while (stream_bits.size() % 32 != 0) begin
            stream_bits.push_back(1'($urandom_range(0, 1)));
        end
        if (!is_last_chain) begin
            repeat (32) stream_bits.push_back(1'($urandom_range(0, 1)));
        end
    endtask

    // well-formed event with random content for the given chain layout
    task automatic build_event(input int n_chains, input int n_asics, input int p_full,
                               input logic dense_ok);
        int          c;
        int          a;
        int          sel;
        logic [4:0]  head5;
        logic [63:0] map;
        stream_bits.delete();
        for (c = 0; c < n_chains; c++) begin
            for (a = 0; a < n_asics; a++) begin
                head5 = 5'($urandom);
                head5[3] = ($urandom_range(0, 99) < p_full);
                map = '0;
                sel = $urandom_range(0, 99);
                if (sel < 12) begin
                    map = '0;
                end else if (dense_ok && sel >= 95) begin
                    map = '1;
                end else if (dense_ok && sel >= 85) begin
                    map = {$urandom, $urandom};
                end else begin
                    repeat ($urandom_range(1, 3)) map[$urandom_range(0, 63)] = 1'b1;
                end
                add_record(head5, map, 10'($urandom), 10'($urandom), -1);
            end
            pad_chain(c == n_chains - 1);
        end
    endtask

    // queue words [first_word, first_word + count) of the bit stream
    task automatic send_span(input logic first_sof, input int first_word, input int count);
        int i;
        int b;
        logic [31:0] w;
        for (i = first_word; i < first_word + count && i < stream_bits.size() / 32; i++) begin
            for (b = 0; b < 32; b++) begin
                w[31 - b] = stream_bits[i * 32 + b];
            end
            send_word(w, (i == first_word) ? first_sof : 1'b0);
        end
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [3:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == arbd_pkg::REG_CHAIN_COUNT) begin
            cfg_chains = val;
        end else begin
            cfg_asics = val;
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // sender holds off until every expected result is in and the parser has run dry
    task automatic settle();
        @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_records.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    logic [3:0] phase_chains[8] = '{4'd2, 4'd8, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd1};
    logic [3:0] phase_asics[8]  = '{4'd3, 4'd8, 4'd8, 4'd1, 4'd15, 4'd0, 4'd2, 4'd1};

    initial begin : sequencer
        int   i;
        int   sel;
        int   n_c;
        int   n_a;
        int   total;
        int   p_full;
        int   first;
        int   half;
        logic dense_ok;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, registers at their reset values
        // first event without a start marker: hits on channel 0 and 63, extreme values
        stream_bits.delete();
        add_record(5'b01001, {1'b1, 62'b0, 1'b1}, 10'd0, 10'd1023, 1023);
        pad_chain(1'b1);
        send_span(1'b0, 0, 1000);
        // trailing word after the last chain is ignored
        send_word(32'hFFFF_FFFF, 1'b0);
        // empty record
        stream_bits.delete();
        add_record(5'b10110, '0, '0, '0, -1);
        pad_chain(1'b1);
        send_span(1'b1, 0, 1000);
        // hit record with a blank map, straight from reference to common mode
        stream_bits.delete();
        add_record(5'b11111, '0, 10'd1023, 10'd0, 0);
        pad_chain(1'b1);
        send_span(1'b1, 0, 1000);
        // two middle channels, zero adc values
        stream_bits.delete();
        add_record(5'b01000, 64'h0000_0001_8000_0000, 10'd1023, 10'd0, 0);
        pad_chain(1'b1);
        send_span(1'b1, 0, 1000);
        // event cut short by a fresh start marker, twice over
        stream_bits.delete();
        add_record(5'b11101, {$urandom, $urandom}, 10'($urandom), 10'($urandom), -1);
        pad_chain(1'b1);
        send_span(1'b1, 0, 2);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        settle();

        // random part over a range of chain layouts, out-of-range values included
        for (i = 0; i < 8; i++) begin
            write_register(arbd_pkg::REG_CHAIN_COUNT, phase_chains[i]);
            write_register(arbd_pkg::REG_ASICS_PER_CHAIN, phase_asics[i]);
            @(negedge aclk);
            steady = (i == 2);
            n_c = effective(cfg_chains);
            n_a = effective(cfg_asics);
            total = n_c * n_a;
            p_full = (total > 16) ? 4 : ((total > 4) ? 35 : 70);
            dense_ok = (total <= 2);
            first = words_sent;
            while (words_sent - first < 16) begin
                build_event(n_c, n_a, p_full, dense_ok);
                // mostly whole events, some truncated
                if ($urandom_range(0, 99) < 12) begin
                    send_span(1'b1, 0, $urandom_range(1, stream_bits.size() / 32));
                end else begin
                    send_span(1'b1, 0, 1000);
                end
                // occasional noise: stray words, or garbage opening a new event
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    repeat ($urandom_range(1, 2)) send_word($urandom, 1'b0);
                end else if (sel < 15) begin
                    send_word($urandom, 1'b1);
                end
            end
            settle();
        end
        steady = 1'b0;

        // every channel hit in one record, still one chain of one asic
        stream_bits.delete();
        add_record(5'b11010, '1, 10'($urandom), 10'($urandom), -1);
        pad_chain(1'b1);
        send_span(1'b1, 0, 1000);
        settle();

        // layout changed halfway through an event while the block is idle
        write_register(arbd_pkg::REG_CHAIN_COUNT, 4'd2);
        write_register(arbd_pkg::REG_ASICS_PER_CHAIN, 4'd2);
        @(negedge aclk);
        build_event(2, 2, 70, 1'b0);
        half = stream_bits.size() / 64;
        send_span(1'b1, 0, half);
        settle();
        write_register(arbd_pkg::REG_ASICS_PER_CHAIN, 4'd1);
        write_register(arbd_pkg::REG_CHAIN_COUNT, 4'd3);
        @(negedge aclk);
        send_span(1'b0, half, 1000);
        send_word($urandom, 1'b0);
        settle();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
